[src/htpid_pkg.sv]
// Shared types and constants for the heading turn PID controller.
// No dependencies; used by all modules in src.
`timescale 1ns / 1ps

package htpid_pkg;

  localparam int unsigned COEF_W         = 40;
  localparam int unsigned LIMIT_W        = 15;
  localparam int unsigned BAND_W         = 10;
  localparam int unsigned TOL_W          = 4;
  localparam int unsigned HEADING_W      = 16;
  localparam int unsigned SPEED_W        = 16;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned TARGET_W       = 9;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 40;
  localparam int unsigned COEF_FRAC_BITS = 24;

  localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 40'sd838907403;
  localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -40'sd838814197;
  localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = 40'sd0;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST      = 15'd6000;
  localparam logic [BAND_W-1:0]        BAND_RST       = 10'd6;
  localparam logic [TOL_W-1:0]         TOL_RST        = 4'd2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_BACK  = 2'd2
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_NOW   = 3'd0,
    CFG_COEF_PREV  = 3'd1,
    CFG_COEF_PREV2 = 3'd2,
    CFG_OUT_LIMIT  = 3'd3,
    CFG_STOP_BAND  = 3'd4,
    CFG_SNAP_TOL   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                        opcode;
    logic [1:0]                  turn_dir;
    logic signed [HEADING_W-1:0] heading;
  } in_beat_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      done_res;
    logic                      active;
  } out_beat_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_now;
    logic signed [COEF_W-1:0] coef_prev;
    logic signed [COEF_W-1:0] coef_prev2;
    logic [LIMIT_W-1:0]       output_limit;
    logic [BAND_W-1:0]        stop_band;
    logic [TOL_W-1:0]         snap_tolerance;
  } cfg_t;

endpackage

[src/htpid_target.sv]
// Start-beat target heading: offset by turn direction, truncate to degrees,
// snap to a multiple of 90, wrap to 0..359. Depends on htpid_pkg.
`timescale 1ns / 1ps

module htpid_target #(
  parameter int unsigned HFB = 6
) (
  input  logic [1:0]                            turn_dir_i,
  input  logic signed [htpid_pkg::HEADING_W-1:0] heading_i,
  input  logic [htpid_pkg::TOL_W-1:0]           snap_tol_i,
  output logic [htpid_pkg::TARGET_W-1:0]        target_o
);

  localparam int unsigned XW = (((HFB + 9) > 16) ? (HFB + 9) : 16) + 1;
  localparam int unsigned MW = XW + 1;
  localparam int unsigned KW = MW + 1;
  localparam int unsigned QW = MW - 8;
  localparam int unsigned RS = MW + 9;
  localparam logic [KW-1:0] RECIP = KW'(((64'd1 << RS) + 64'd359) / 64'd360);
  localparam logic [MW-1:0] OFFSET = MW'(64'd360 << (XW - 8));
  localparam logic signed [XW-1:0] QUARTER = XW'(64'd90 << HFB);
  localparam logic signed [XW-1:0] HALF = XW'(64'd180 << HFB);
  localparam logic signed [XW-1:0] ROUND = XW'((64'd1 << HFB) - 64'd1);

  logic signed [XW-1:0] base;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] t;
  logic signed [XW-1:0] ts;
  logic [MW-1:0]        m;
  logic [MW+KW-1:0]     prod;
  logic [QW-1:0]        q;
  logic [MW-1:0]        q360;
  logic [MW-1:0]        r;

  function automatic logic near(input logic signed [XW-1:0] tv,
                                input logic signed [XW-1:0] c,
                                input logic [htpid_pkg::TOL_W-1:0] tol);
    logic signed [XW:0] d;
    logic [XW:0] mag;
    d = {c[XW-1], c} - {tv[XW-1], tv};
    mag = d[XW] ? -d : d;
    return mag <= (XW+1)'(tol);
  endfunction

  always_comb begin
    case (turn_dir_i)
      htpid_pkg::DIR_RIGHT: base = -QUARTER;
      htpid_pkg::DIR_LEFT:  base = QUARTER;
      default:              base = HALF;
    endcase
  end

  assign x  = base + {{(XW-htpid_pkg::HEADING_W){heading_i[htpid_pkg::HEADING_W-1]}}, heading_i};
  assign xr = x[XW-1] ? (x + ROUND) : x;
  assign t  = xr >>> HFB;

  always_comb begin
    if (near(t, XW'(0), snap_tol_i)) begin
      ts = XW'(0);
    end else if (near(t, XW'(90), snap_tol_i)) begin
      ts = XW'(90);
    end else if (near(t, XW'(180), snap_tol_i)) begin
      ts = XW'(180);
    end else if (near(t, XW'(270), snap_tol_i)) begin
      ts = XW'(270);
    end else if (near(t, XW'(360), snap_tol_i)) begin
      ts = XW'(0);
    end else begin
      ts = t;
    end
  end

  // shift to a positive value, then floor(m/360) by reciprocal multiply
  assign m    = {ts[XW-1], ts} + OFFSET;
  assign prod = (MW+KW)'(m) * (MW+KW)'(RECIP);
  assign q    = prod[RS+QW-1:RS];
  assign q360 = (MW'(q) << 8) + (MW'(q) << 6) + (MW'(q) << 5) + (MW'(q) << 3);
  assign r    = m - q360;
  assign target_o = r[htpid_pkg::TARGET_W-1:0];

endmodule

[src/htpid_pid.sv]
// Turn state and incremental PID update with saturating accumulator and
// output clamp. Produces the result of one beat. Depends on htpid_pkg.
`timescale 1ns / 1ps

module htpid_pid #(
  parameter int unsigned HFB = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  htpid_pkg::in_beat_t               beat_i,
  input  logic [htpid_pkg::TARGET_W-1:0]    target_i,
  input  htpid_pkg::cfg_t                   cfg_i,
  output htpid_pkg::out_beat_t              res_o
);

  localparam int unsigned TW = HFB + 10;
  localparam int unsigned EW = ((TW > 16) ? TW : 16) + 1;
  localparam int unsigned PW = htpid_pkg::COEF_W + EW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned AW = htpid_pkg::ACC_W;
  localparam int unsigned FB = htpid_pkg::COEF_FRAC_BITS + HFB;
  localparam int unsigned VW = htpid_pkg::SPEED_W;

  logic [htpid_pkg::TARGET_W-1:0] target_q;
  logic                           neg_q;
  logic signed [EW-1:0]           e1_q;
  logic signed [EW-1:0]           e2_q;
  logic signed [AW-1:0]           acc_q;
  logic                           turning_q;

  logic signed [EW-1:0] tgt_s;
  logic signed [EW-1:0] hd;
  logic signed [EW-1:0] diff;
  logic signed [EW-1:0] e0;
  logic [EW-1:0]        e0_mag;
  logic                 stop;
  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic signed [SW-1:0] sum;
  logic signed [AW:0]   wide;
  logic signed [AW-1:0] acc_d;
  logic signed [AW-1:0] limq;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] vt;
  logic signed [VW-1:0] lim_s;
  logic signed [VW-1:0] v;

  assign tgt_s  = $signed(EW'(target_q)) <<< HFB;
  assign hd     = {{(EW-htpid_pkg::HEADING_W){beat_i.heading[htpid_pkg::HEADING_W-1]}},
                   beat_i.heading};
  assign diff   = tgt_s - hd;
  assign e0     = neg_q ? -diff : diff;
  assign e0_mag = e0[EW-1] ? -e0 : e0;
  assign stop   = e0_mag < EW'(cfg_i.stop_band);

  assign p0  = $signed(cfg_i.coef_now) * e0;
  assign p1  = $signed(cfg_i.coef_prev) * e1_q;
  assign p2  = $signed(cfg_i.coef_prev2) * e2_q;
  assign sum = SW'(p0) + SW'(p1) + SW'(p2);

  assign wide = {acc_q[AW-1], acc_q} + (AW+1)'(sum);

  always_comb begin
    if (wide[AW] != wide[AW-1]) begin
      acc_d = wide[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      acc_d = wide[AW-1:0];
    end
  end

  assign limq  = $signed(AW'(cfg_i.output_limit) << FB);
  assign acc_r = acc_d[AW-1] ? (acc_d + $signed((AW'(1) << FB) - AW'(1))) : acc_d;
  assign vt    = acc_r >>> FB;
  assign lim_s = $signed({1'b0, cfg_i.output_limit});

  always_comb begin
    if (acc_d > limq) begin
      v = lim_s;
    end else if (acc_d < -limq) begin
      v = -lim_s;
    end else begin
      v = vt[VW-1:0];
    end
  end

  always_comb begin
    res_o = '0;
    if (beat_i.opcode == htpid_pkg::OP_START) begin
      res_o.active = 1'b1;
    end else if (turning_q) begin
      if (stop) begin
        res_o.done_res = 1'b1;
      end else begin
        res_o.left_speed  = neg_q ? v : -v;
        res_o.right_speed = neg_q ? -v : v;
        res_o.active      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      neg_q     <= 1'b0;
      e1_q      <= '0;
      e2_q      <= '0;
      acc_q     <= '0;
      turning_q <= 1'b0;
    end else if (step_i) begin
      if (beat_i.opcode == htpid_pkg::OP_START) begin
        target_q  <= target_i;
        neg_q     <= (beat_i.turn_dir == htpid_pkg::DIR_RIGHT);
        e1_q      <= '0;
        e2_q      <= '0;
        acc_q     <= '0;
        turning_q <= 1'b1;
      end else if (turning_q) begin
        e2_q  <= e1_q;
        e1_q  <= e0;
        acc_q <= acc_d;
        if (stop) begin
          turning_q <= 1'b0;
        end
      end
    end
  end

endmodule

[src/heading_turn_pid_controller_core.sv]
// Top level of the heading turn PID controller: input register, config
// registers, result register. Uses htpid_pkg, htpid_target, htpid_pid.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i) carries start beats
//    (direction plus heading) and tick beats (heading). Every input beat
//    gives exactly one result beat on out_valid_o/out_ready_i/out_data_o.
//  - A beat is held in the input register, then the target, error, PID
//    update, clamp and completion check run combinationally into the result
//    register, which takes the result when it is empty or out_ready_i is high.
//  - Throughput is one beat per cycle unless stalled; the PID state is
//    updated as a beat enters the result register; the next tick sees it at once.
//  - When the receiver stalls, the result register holds and the input
//    register still takes one more beat; in_ready_o drops only when both
//    are full and out_ready_i is low.
//  - Config port (cfg_we_i/cfg_idx_i/cfg_data_i) writes a register; write
//    only while no beat is in flight.
//  - Reset clears the turn state (idle, zero errors and accumulator), empties
//    both registers and loads the default coefficients and limits.
module heading_turn_pid_controller_core #(
  parameter int unsigned HEADING_FRAC_BITS = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  htpid_pkg::in_beat_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output htpid_pkg::out_beat_t                 out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [htpid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [htpid_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  htpid_pkg::in_beat_t             in_q;
  logic                            in_valid_q;
  htpid_pkg::out_beat_t            out_q;
  logic                            out_valid_q;
  htpid_pkg::cfg_t                 cfg_q;
  htpid_pkg::out_beat_t            res;
  logic [htpid_pkg::TARGET_W-1:0]  target;
  logic                            advance;
  logic                            step;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_now       <= htpid_pkg::COEF_NOW_RST;
      cfg_q.coef_prev      <= htpid_pkg::COEF_PREV_RST;
      cfg_q.coef_prev2     <= htpid_pkg::COEF_PREV2_RST;
      cfg_q.output_limit   <= htpid_pkg::LIMIT_RST;
      cfg_q.stop_band      <= htpid_pkg::BAND_RST;
      cfg_q.snap_tolerance <= htpid_pkg::TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        htpid_pkg::CFG_COEF_NOW:   cfg_q.coef_now   <= $signed(cfg_data_i[htpid_pkg::COEF_W-1:0]);
        htpid_pkg::CFG_COEF_PREV:  cfg_q.coef_prev  <= $signed(cfg_data_i[htpid_pkg::COEF_W-1:0]);
        htpid_pkg::CFG_COEF_PREV2: cfg_q.coef_prev2 <= $signed(cfg_data_i[htpid_pkg::COEF_W-1:0]);
        htpid_pkg::CFG_OUT_LIMIT:  cfg_q.output_limit <= cfg_data_i[htpid_pkg::LIMIT_W-1:0];
        htpid_pkg::CFG_STOP_BAND:  cfg_q.stop_band <= cfg_data_i[htpid_pkg::BAND_W-1:0];
        htpid_pkg::CFG_SNAP_TOL:   cfg_q.snap_tolerance <= cfg_data_i[htpid_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  htpid_target #(
    .HFB (HEADING_FRAC_BITS)
  ) u_target (
    .turn_dir_i (in_q.turn_dir),
    .heading_i  (in_q.heading),
    .snap_tol_i (cfg_q.snap_tolerance),
    .target_o   (target)
  );

  htpid_pid #(
    .HFB (HEADING_FRAC_BITS)
  ) u_pid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .beat_i   (in_q),
    .target_i (target),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[test/tb_heading_turn_pid_controller_core.sv]
// Testbench for heading_turn_pid_controller_core: random valid/ready traffic
// checked beat by beat against an in-bench turn controller predictor.
// Depends on src/htpid_pkg.sv and src/heading_turn_pid_controller_core.sv.
`timescale 1ns / 1ps

module tb_heading_turn_pid_controller_core;

  localparam int HdgFrac = 6;
  localparam int HdgScale = 1 << HdgFrac;
  localparam int FracAll = int'(htpid_pkg::COEF_FRAC_BITS) + HdgFrac;
  localparam int HdgMax = 23040;
  localparam int CycleLimit = 200000;
  localparam logic [1:0] DirUndef = 2'd3;  // decoded as back
  localparam longint AccMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint AccMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [htpid_pkg::COEF_W-1:0] CoefTop = 40'sh7F_FFFF_FFFF;
  localparam logic signed [htpid_pkg::COEF_W-1:0] CoefBottom = 40'sh80_0000_0000;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  htpid_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  htpid_pkg::out_beat_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [htpid_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [htpid_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  heading_turn_pid_controller_core #(
    .HEADING_FRAC_BITS(HdgFrac)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor copy of the registers
  longint k_now = longint'(htpid_pkg::COEF_NOW_RST);
  longint k_prev = longint'(htpid_pkg::COEF_PREV_RST);
  longint k_prev2 = longint'(htpid_pkg::COEF_PREV2_RST);
  int lim_q = int'(htpid_pkg::LIMIT_RST);
  int band_q = int'(htpid_pkg::BAND_RST);
  int tol_q = int'(htpid_pkg::TOL_RST);

  // predictor copy of the turn state
  int aim_deg = 0;
  bit aim_neg = 1'b0;
  int err_prev = 0;
  int err_prev2 = 0;
  longint drive_acc = 0;
  bit turning = 1'b0;

  htpid_pkg::in_beat_t beats_to_send[$];
  htpid_pkg::out_beat_t drive_due[$];
  int beats_queued = 0;
  int results_seen = 0;
  int beat_cnt = 0;
  int fail_cnt = 0;
  int idle_pct = 30;
  int hold_left = 0;
  int cycle_cnt = 0;

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int aim_of(logic [1:0] dir, int hdg, int tol);
    int d, t;
    d = (dir == htpid_pkg::DIR_RIGHT) ? -1 : ((dir == htpid_pkg::DIR_LEFT) ? 1 : 2);
    t = (d * 90 * HdgScale + hdg) / HdgScale;
    if (iabs(t) <= tol) t = 0;
    else if (iabs(90 - t) <= tol) t = 90;
    else if (iabs(180 - t) <= tol) t = 180;
    else if (iabs(270 - t) <= tol) t = 270;
    else if (iabs(360 - t) <= tol) t = 0;
    t = t % 360;
    if (t < 0) t += 360;
    return t;
  endfunction

  function automatic htpid_pkg::out_beat_t steer_step(htpid_pkg::in_beat_t b);
    htpid_pkg::out_beat_t r;
    int sgn, e0;
    longint sum, acc, limq, v;
    r = '0;
    if (b.opcode == htpid_pkg::OP_START) begin
      aim_deg = aim_of(b.turn_dir, int'($signed(b.heading)), tol_q);
      aim_neg = (b.turn_dir == htpid_pkg::DIR_RIGHT);
      err_prev = 0;
      err_prev2 = 0;
      drive_acc = 0;
      turning = 1'b1;
    end else if (turning) begin
      sgn = aim_neg ? -1 : 1;
      e0 = sgn * (aim_deg * HdgScale - int'($signed(b.heading)));
      sum = k_prev2 * longint'(err_prev2) + k_prev * longint'(err_prev)
          + k_now * longint'(e0);
      err_prev2 = err_prev;
      err_prev = e0;
      acc = drive_acc + sum;
      if (drive_acc[63] == sum[63] && acc[63] != sum[63]) acc = sum[63] ? AccMin : AccMax;
      drive_acc = acc;
      if (iabs(e0) < band_q) begin
        r.done_res = 1'b1;
        turning = 1'b0;
      end else begin
        limq = longint'(lim_q) <<< FracAll;
        if (drive_acc > limq) v = lim_q;
        else if (drive_acc < -limq) v = -lim_q;
        else if (drive_acc >= 0) v = drive_acc >>> FracAll;
        else v = -((-drive_acc) >>> FracAll);
        r.left_speed = 16'(-sgn * v);
        r.right_speed = 16'(sgn * v);
      end
    end
    r.active = turning;
    return r;
  endfunction

  function automatic int any_heading();
    return int'($urandom_range(2 * HdgMax)) - HdgMax;
  endfunction

  function automatic int clip_hdg(int h);
    return (h > HdgMax) ? HdgMax : ((h < -HdgMax) ? -HdgMax : h);
  endfunction

  function automatic htpid_pkg::cfg_t rand_cfg();
    htpid_pkg::cfg_t c;
    c.coef_now = $signed({8'($urandom), 32'($urandom)}) >>> $urandom_range(0, 14);
    c.coef_prev = $signed({8'($urandom), 32'($urandom)}) >>> $urandom_range(0, 14);
    c.coef_prev2 = $signed({8'($urandom), 32'($urandom)}) >>> $urandom_range(0, 14);
    c.output_limit = 15'($urandom_range(32767));
    c.stop_band = 10'($urandom_range(1, 300));
    c.snap_tolerance = 4'($urandom_range(15));
    return c;
  endfunction

  task automatic add_item(htpid_pkg::op_e op, logic [1:0] dir, int h);
    beats_to_send.push_back('{opcode: op, turn_dir: dir, heading: 16'(h)});
    beats_queued++;
  endtask

  // start, a decaying error series, optionally a final tick inside the stop band, then up to two random ticks
  task automatic add_turn(bit finish);
    logic [1:0] dir;
    int h, aim, s, err;
    dir = ($urandom_range(19) == 0) ? DirUndef : 2'($urandom_range(2));
    h = any_heading();
    add_item(htpid_pkg::OP_START, dir, h);
    aim = aim_of(dir, h, tol_q);
    s = (dir == htpid_pkg::DIR_RIGHT) ? -1 : 1;
    err = int'($urandom_range(100, 12000));
    if ($urandom_range(1)) err = -err;
    repeat ($urandom_range(1, 12)) begin
      add_item(htpid_pkg::OP_TICK, 2'($urandom), clip_hdg(aim * HdgScale - s * err));
      err = err * int'($urandom_range(20, 90)) / 100;
      if ($urandom_range(5) == 0) err = -err;
    end
    if (finish && band_q > 0) begin
      err = int'($urandom_range(band_q - 1));
      if ($urandom_range(1)) err = -err;
      add_item(htpid_pkg::OP_TICK, 2'($urandom), clip_hdg(aim * HdgScale - s * err));
    end
    repeat ($urandom_range(0, 2)) add_item(htpid_pkg::OP_TICK, 2'($urandom), any_heading());
  endtask

  task automatic run_mix(int n);
    int stop_at;
    stop_at = beats_queued + n;
    while (beats_queued < stop_at) begin
      if ($urandom_range(99) < 75) add_turn($urandom_range(4) != 0);
      else add_item(htpid_pkg::op_e'($urandom_range(1)), 2'($urandom), any_heading());
    end
  endtask

  task automatic drain();
    while (results_seen != beats_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_cfg(htpid_pkg::cfg_t c);
    htpid_pkg::cfg_reg_e idx;
    idx = htpid_pkg::CFG_COEF_NOW;
    repeat (idx.num()) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      case (idx)
        htpid_pkg::CFG_COEF_NOW: cfg_data_i <= c.coef_now;
        htpid_pkg::CFG_COEF_PREV: cfg_data_i <= c.coef_prev;
        htpid_pkg::CFG_COEF_PREV2: cfg_data_i <= c.coef_prev2;
        htpid_pkg::CFG_OUT_LIMIT: cfg_data_i <= htpid_pkg::CFG_DATA_W'(c.output_limit);
        htpid_pkg::CFG_STOP_BAND: cfg_data_i <= htpid_pkg::CFG_DATA_W'(c.stop_band);
        default: cfg_data_i <= htpid_pkg::CFG_DATA_W'(c.snap_tolerance);
      endcase
      idx = idx.next();
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_now = longint'(c.coef_now);
    k_prev = longint'(c.coef_prev);
    k_prev2 = longint'(c.coef_prev2);
    lim_q = int'(c.output_limit);
    band_q = int'(c.stop_band);
    tol_q = int'(c.snap_tolerance);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : drv
    logic nxt_valid;
    htpid_pkg::in_beat_t nxt_data;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_data = in_data_i;
      if (in_valid_i && in_ready_o) begin
        drive_due.push_back(steer_step(in_data_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && beats_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt_data = beats_to_send.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid_i <= nxt_valid;
      in_data_i <= nxt_data;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : mon
    htpid_pkg::out_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (drive_due.size() == 0) begin
          $error("result beat with no expected beat pending");
          fail_cnt++;
        end else begin
          want = drive_due.pop_front();
          results_seen++;
          beat_cnt++;
          if (want.left_speed !== out_data_o.left_speed) begin
            $error("left_speed: expected %0d, got %0d", want.left_speed, out_data_o.left_speed);
            fail_cnt++;
          end
          if (want.right_speed !== out_data_o.right_speed) begin
            $error("right_speed: expected %0d, got %0d", want.right_speed,
                   out_data_o.right_speed);
            fail_cnt++;
          end
          if (want.done_res !== out_data_o.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_data_o.done_res);
            fail_cnt++;
          end
          if (want.active !== out_data_o.active) begin
            $error("active: expected %0d, got %0d", want.active, out_data_o.active);
            fail_cnt++;
          end
          // long back-pressure so the input side fills and stalls
          if (beat_cnt == 250 || beat_cnt == 1000) hold_left = 150;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    htpid_pkg::cfg_t c;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset configuration
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_RIGHT, 0);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_RIGHT, 0);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_RIGHT, 0);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_RIGHT, 17000);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_RIGHT, 17278);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_LEFT, 100);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_LEFT, HdgMax);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_LEFT, -HdgMax);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_LEFT, HdgMax);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_BACK, -HdgMax);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_BACK, HdgMax);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_BACK, -1);
    add_item(htpid_pkg::OP_START, DirUndef, 5000);
    add_item(htpid_pkg::OP_TICK, DirUndef, 16512);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_LEFT, -64);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_RIGHT, -63);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_RIGHT, 300);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_LEFT, 17152);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_LEFT, 192);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_LEFT, -5);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_RIGHT, 5696);
    add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_BACK, HdgMax);
    drain();

    load_cfg(rand_cfg());
    run_mix(250);
    drain();

    c = '{coef_now: CoefTop, coef_prev: CoefTop, coef_prev2: CoefTop,
          output_limit: 15'h7FFF, stop_band: 10'h3FF, snap_tolerance: 4'hF};
    load_cfg(c);
    run_mix(150);
    drain();

    // accumulator saturation, positive then negative
    c.stop_band = '0;
    c.snap_tolerance = '0;
    load_cfg(c);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_LEFT, -HdgMax);
    repeat (230) add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_LEFT, -HdgMax);
    add_item(htpid_pkg::OP_START, htpid_pkg::DIR_RIGHT, HdgMax);
    repeat (150) add_item(htpid_pkg::OP_TICK, htpid_pkg::DIR_RIGHT, -HdgMax);
    drain();

    c = '{coef_now: CoefBottom, coef_prev: CoefBottom, coef_prev2: CoefBottom,
          output_limit: '0, stop_band: '0, snap_tolerance: '0};
    load_cfg(c);
    run_mix(150);
    drain();

    c = '{coef_now: htpid_pkg::COEF_NOW_RST, coef_prev: htpid_pkg::COEF_PREV_RST,
          coef_prev2: htpid_pkg::COEF_PREV2_RST, output_limit: htpid_pkg::LIMIT_RST,
          stop_band: htpid_pkg::BAND_RST, snap_tolerance: htpid_pkg::TOL_RST};
    load_cfg(c);
    idle_pct = 0;
    run_mix(300);
    drain();
    idle_pct = 30;

    load_cfg(rand_cfg());
    run_mix(300);
    drain();

    load_cfg(rand_cfg());
    run_mix(300);
    drain();

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
